// ===== rtl/echo_pulse_ranging_average_top_macros.svh =====
// Assertion macros for the echo pulse ranging block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ECHO_PULSE_RANGING_AVERAGE_TOP_MACROS_SVH
`define ECHO_PULSE_RANGING_AVERAGE_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define EPRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("epra: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define EPRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("epra: next-cycle check failed");

`else

`define EPRA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EPRA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/epra_pkg.sv =====
// Shared constants for the echo pulse ranging block.
// No dependencies; every file but the assertion macro header uses this package.
package epra_pkg;

	// Field widths.
	localparam int TIME_W = 16;
	localparam int DIST_W = 10;

	// Largest distance a 16-bit pulse width can give: floor(65535 / 116).
	localparam int DIST_MAX = 564;

	// Default averaging window.
	localparam int WINDOW_DEFAULT = 10;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;

	// floor(floor(w / 2) / 58) equals floor(floor(w / 4) / 29).
	// The division by 29 is a multiply by ceil(2^19 / 29) and a shift,
	// exact for every 14-bit quotient input.
	localparam int DIV_PRE_SHIFT = 2;
	localparam int DIV_MULT      = 18079;
	localparam int DIV_MULT_W    = 15;
	localparam int DIV_SHIFT     = 19;

	// Shift used for the reciprocal of the window length.
	localparam int AVG_SHIFT  = 24;
	localparam int AVG_MULT_W = AVG_SHIFT + 1;

endpackage

// ===== rtl/epra_edge_if.sv =====
// Channel carrying echo edge capture events.
// Depends on epra_pkg for the timer width.
interface epra_edge_if;
	logic                         valid;
	logic                         ready;
	logic [epra_pkg::TIME_W-1:0] edge_time;

	modport source (output valid, output edge_time, input ready);
	modport sink   (input valid, input edge_time, output ready);
endinterface

// ===== rtl/epra_range_if.sv =====
// Channel carrying distance results and their moving average.
// Depends on epra_pkg for the distance width.
interface epra_range_if;
	logic                         valid;
	logic                         ready;
	logic [epra_pkg::DIST_W-1:0] pulse_cm;
	logic [epra_pkg::DIST_W-1:0] average_cm;

	modport source (output valid, output pulse_cm, output average_cm, input ready);
	modport sink   (input valid, input pulse_cm, input average_cm, output ready);
endinterface

// ===== rtl/epra_front.sv =====
// Front part: pairs rising and falling echo edges and forms pulse widths.
// Depends on epra_pkg; feeds epra_queue.
module epra_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         edge_valid,
	output logic                         edge_ready,
	input  logic [epra_pkg::TIME_W-1:0] edge_time,
	input  logic                         queue_full,
	output logic                         push_valid,
	output logic [epra_pkg::TIME_W-1:0] push_width
);
	import epra_pkg::*;

	logic              awaiting_fall_q;
	logic [TIME_W-1:0] rise_time_q;
	logic              edge_fire;

	// An edge is taken whenever the queue has room for a possible width.
	assign edge_ready = !queue_full;
	assign edge_fire  = edge_valid && edge_ready;

	// A falling edge pushes the modulo-2^16 pulse width.
	assign push_valid = edge_fire && awaiting_fall_q;
	assign push_width = edge_time - rise_time_q;

	// Edges simply alternate rise, fall, rise from reset onward.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_fall_q <= 1'b0;
			rise_time_q     <= '0;
		end else if (edge_fire) begin
			awaiting_fall_q <= !awaiting_fall_q;
			if (!awaiting_fall_q) begin
				rise_time_q <= edge_time;
			end
		end
	end

endmodule

// ===== rtl/epra_queue.sv =====
// Short queue of pulse widths between the front and back parts.
// Depends on epra_pkg and the assertion macro header.
`include "echo_pulse_ranging_average_top_macros.svh"

module epra_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push_valid,
	input  logic [epra_pkg::TIME_W-1:0] push_width,
	output logic                         full,
	output logic                         pop_valid,
	input  logic                         pop_ready,
	output logic [epra_pkg::TIME_W-1:0] pop_width
);
	import epra_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [TIME_W-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop_fire;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_width = slot_q[rd_ptr_q];
	assign pop_fire  = pop_valid && pop_ready;

	// Storage for queued widths.
	always_ff @(posedge clk) begin
		if (push_valid) begin
			slot_q[wr_ptr_q] <= push_width;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_valid && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (!push_valid && pop_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The fill count stays within the depth, the front never overfills, and a push without a pop raises the count.
	`EPRA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
	`EPRA_ASSERT_IMP(a_no_overfill, clk, arst_n, push_valid, !full)
	`EPRA_ASSERT_NXT(a_count_grows, clk, arst_n, push_valid && !pop_fire,
		count_q == $past(count_q) + 1'b1)

endmodule

// ===== rtl/epra_back.sv =====
// Back part: converts widths to distances, keeps the ring and running sum,
// and registers the result. Depends on epra_pkg and the assertion macro header.
`include "echo_pulse_ranging_average_top_macros.svh"

module epra_back #(
	parameter int WINDOW = epra_pkg::WINDOW_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  logic [epra_pkg::TIME_W-1:0] pop_width,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [epra_pkg::DIST_W-1:0] pulse_cm,
	output logic [epra_pkg::DIST_W-1:0] average_cm
);
	import epra_pkg::*;

	localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_MAX    = DIST_MAX * WINDOW;
	localparam int SUM_W      = $clog2(SUM_MAX + 1);
	localparam int QUOT_W     = TIME_W - DIV_PRE_SHIFT;
	localparam int DPROD_W    = QUOT_W + DIV_MULT_W;
	localparam int APROD_W    = SUM_W + AVG_MULT_W;
	localparam int AVG_MULT   = ((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;

	// Ring of recent distances, with a valid bit per entry cleared at reset.
	logic [DIST_W-1:0]  ring_mem [WINDOW];
	logic [WINDOW-1:0]  ring_valid_q;

	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  slot_next;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   sum_new;

	logic               v_s1;
	logic [DIST_W-1:0]  dist_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [DIST_W-1:0]  old_s1;

	logic               v_s2;
	logic [DIST_W-1:0]  dist_s2;
	logic [SUM_W-1:0]   sum_s2;

	logic               out_valid_q;
	logic [DIST_W-1:0]  distance_q;
	logic [DIST_W-1:0]  average_q;

	logic               adv;
	logic               pop_fire;
	logic               fwd_hit;
	logic [DPROD_W-1:0] dist_prod;
	logic [APROD_W-1:0] avg_prod;

	// The whole pipeline moves when the output register is free.
	assign adv       = !out_valid_q || out_ready;
	assign pop_ready = adv;
	assign pop_fire  = pop_valid && adv;

	// The slot is advanced before the write; it wraps at the window length.
	assign slot_next = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;

	// Width to centimetres: drop two bits, then multiply by the reciprocal of 29.
	assign dist_prod = DPROD_W'(pop_width[TIME_W-1:DIV_PRE_SHIFT])
		* DPROD_W'(DIV_MULT);

	// The entry read this cycle is the one stage 1 writes now.
	assign fwd_hit = v_s1 && (slot_s1 == slot_next);

	// New running sum: drop the overwritten entry, add the new distance.
	assign sum_new = sum_q - SUM_W'(old_s1) + SUM_W'(dist_s1);

	// Average by multiplying with the reciprocal of the window length.
	assign avg_prod = APROD_W'(sum_s2) * APROD_W'(AVG_MULT);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= '0;
			sum_q        <= '0;
			ring_valid_q <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop_fire;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
			if (pop_fire) begin
				slot_q <= slot_next;
			end
			if (v_s1) begin
				sum_q                 <= sum_new;
				ring_valid_q[slot_s1] <= 1'b1;
			end
		end
	end

	// Ring write at the end of stage 1.
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			ring_mem[slot_s1] <= dist_s1;
		end
	end

	// Stage 1: distance, slot and the registered read of the old entry.
	always_ff @(posedge clk) begin
		if (pop_fire) begin
			dist_s1 <= dist_prod[DIV_SHIFT +: DIST_W];
			slot_s1 <= slot_next;
			if (fwd_hit) begin
				old_s1 <= dist_s1;
			end else if (ring_valid_q[slot_next]) begin
				old_s1 <= ring_mem[slot_next];
			end else begin
				old_s1 <= '0;
			end
		end
	end

	// Stage 2 and the output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s1) begin
				dist_s2 <= dist_s1;
				sum_s2  <= sum_new;
			end
			if (v_s2) begin
				distance_q <= dist_s2;
				average_q  <= avg_prod[AVG_SHIFT +: DIST_W];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign pulse_cm   = distance_q;
	assign average_cm = average_q;

	// The sum stays within the window's range, the average within the largest distance,
	// and a stalled stage 1 keeps its distance.
	`EPRA_ASSERT_IMP(a_sum_bound, clk, arst_n, 1'b1, sum_q <= SUM_W'(SUM_MAX))
	`EPRA_ASSERT_IMP(a_avg_bound, clk, arst_n, out_valid_q, average_q <= DIST_W'(DIST_MAX))
	`EPRA_ASSERT_NXT(a_s1_hold, clk, arst_n, v_s1 && !adv, v_s1 && $stable(dist_s1))

endmodule

// ===== rtl/echo_pulse_ranging_average_top.sv =====
// Echo pulse ranging with a moving average. Capture events alternate rising and falling
// edges starting with a rising edge after reset; a rising edge stores its time and gives
// no result, a falling edge gives the distance floor(width / 116) cm of the modulo-2^16
// pulse width together with the floor mean of the last WINDOW distances (entries not yet
// written count as zero). One event is taken per clock cycle while the queue has room; a
// falling edge's result then passes the queue, stages 1 and 2 and the output register.
// The rate is set by the running-sum register, updated at most once per cycle in the
// back part. A two-entry queue between the edge-pairing front part and the arithmetic
// back part lets events keep arriving while a result waits to be taken. Depends on
// epra_pkg, the two channel interfaces and the front, queue and back modules.
module echo_pulse_ranging_average_top #(
	parameter int WINDOW = epra_pkg::WINDOW_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	epra_edge_if.sink    echo_edge,
	epra_range_if.source range_result
);
	import epra_pkg::*;

	logic              queue_full;
	logic              push_valid;
	logic [TIME_W-1:0] push_width;
	logic              pop_valid;
	logic              pop_ready;
	logic [TIME_W-1:0] pop_width;

	// Edge pairing and width formation.
	epra_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_valid (echo_edge.valid),
		.edge_ready (echo_edge.ready),
		.edge_time  (echo_edge.edge_time),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_width (push_width)
	);

	// Width queue between the two parts.
	epra_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_width (push_width),
		.full       (queue_full),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_width  (pop_width)
	);

	// Distance conversion, ring, running sum and result register.
	epra_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_width  (pop_width),
		.out_valid  (range_result.valid),
		.out_ready  (range_result.ready),
		.pulse_cm   (range_result.pulse_cm),
		.average_cm (range_result.average_cm)
	);

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for echo_pulse_ranging_average_top: drives echo edge
// transfers, predicts distance and moving average per falling edge, checks results.
// Depends on epra_pkg, epra_edge_if, epra_range_if and the RTL of the block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import epra_pkg::*;

	localparam int WINDOW       = WINDOW_DEFAULT;
	localparam int SUM_W        = 13;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT   = 1000;
	localparam int HOLD_CYCLES  = 80;

	typedef struct packed {
		logic [DIST_W-1:0] pulse_cm;
		logic [DIST_W-1:0] average_cm;
	} range_t;

	logic clk;
	logic arst_n;

	epra_edge_if  echo_ch();
	epra_range_if range_ch();

	echo_pulse_ranging_average_top #(.WINDOW(WINDOW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.echo_edge(echo_ch),
		.range_result(range_ch)
	);

	// Predictor state: edge pairing, distance history ring and its running sum.
	logic              awaiting_fall;
	logic [TIME_W-1:0] rise_stamp;
	logic [DIST_W-1:0] distance_hist [WINDOW];
	logic [3:0]        last_slot;
	logic [SUM_W-1:0]  distance_sum;
	range_t            pending_ranges [$];

	int unsigned fail_count;
	int unsigned idle_cycles;
	int unsigned stall_left;
	int unsigned hold_left;
	bit          tx_gaps_on;
	bit          rx_stalls_on;
	bit          hold_req;

	always #HALF_PERIOD clk = ~clk;

	// Idle lengths: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Pulse widths aimed at zero, full scale, centimetre steps and typical echoes, with some fully random.
	function automatic logic [TIME_W-1:0] random_width();
		int unsigned steps;
		case ($urandom_range(0, 9))
			0: return TIME_W'($urandom);
			1: return '0;
			2: return TIME_W'(65535 - $urandom_range(0, 200));
			3: begin
				steps = $urandom_range(1, DIST_MAX);
				return TIME_W'(116 * steps - 1 + $urandom_range(0, 2));
			end
			default: return TIME_W'($urandom_range(1, 6000));
		endcase
	endfunction

	// Update the predictor with one accepted edge; a falling edge queues a result.
	function automatic void predict_echo(input logic [TIME_W-1:0] stamp);
		logic [TIME_W-1:0] width;
		logic [DIST_W-1:0] cm_now;
		range_t            exp_range;
		if (!awaiting_fall) begin
			rise_stamp    = stamp;
			awaiting_fall = 1'b1;
		end else begin
			awaiting_fall = 1'b0;
			width         = stamp - rise_stamp;
			cm_now        = DIST_W'((width >> 1) / 58);
			last_slot     = (last_slot == WINDOW - 1) ? '0 : last_slot + 1'b1;
			distance_sum  = distance_sum - distance_hist[last_slot] + cm_now;
			distance_hist[last_slot] = cm_now;
			exp_range.pulse_cm   = cm_now;
			exp_range.average_cm = DIST_W'(distance_sum / WINDOW);
			pending_ranges.push_back(exp_range);
		end
	endfunction

	task automatic report_error(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	// Offer one edge until the transfer happens, then idle for a random gap when gaps are on.
	task automatic send_echo(input logic [TIME_W-1:0] stamp);
		int unsigned gap;
		echo_ch.valid     <= 1'b1;
		echo_ch.edge_time <= stamp;
		do @(posedge clk); while (!echo_ch.ready);
		predict_echo(stamp);
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			echo_ch.valid     <= 1'b0;
			echo_ch.edge_time <= TIME_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_pulse(input logic [TIME_W-1:0] rise, input logic [TIME_W-1:0] width);
		send_echo(rise);
		send_echo(rise + width);
	endtask

	// Stop offering and wait until every predicted result has been taken.
	task automatic end_phase();
		echo_ch.valid <= 1'b0;
		while (pending_ranges.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Equal times, full scale, timer wrap, centimetre boundaries and the ring wrap.
	task automatic test_directed_widths();
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		send_pulse(16'h0000, 16'd0);
		send_pulse(16'h0000, 16'hFFFF);
		send_pulse(16'hFFFF, 16'hFFFF);
		send_pulse(16'hFF00, 16'h0200);
		send_pulse(16'h1234, 16'd115);
		send_pulse(16'h8000, 16'd116);
		send_pulse(16'h7FFF, 16'd231);
		send_pulse(16'hAAAA, 16'd232);
		send_pulse(16'h5555, 16'd3480);
		send_pulse(16'h0001, 16'd65534);
		send_pulse(16'hC3A5, 16'd58000);
		end_phase();
	endtask

	// Random pulses on both sides idling, with runs of full-scale pulses now and then.
	task automatic test_random_traffic(input int unsigned pulses);
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		for (int unsigned i = 0; i < pulses; i++) begin
			if ($urandom_range(0, 39) == 0) begin
				for (int k = 0; k < WINDOW; k++)
					send_pulse(TIME_W'($urandom), TIME_W'(65535 - $urandom_range(0, 3)));
			end else begin
				send_pulse(TIME_W'($urandom), random_width());
			end
		end
		end_phase();
	endtask

	// Full-rate transfers with no idling on either side.
	task automatic test_back_to_back(input int unsigned pulses);
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		for (int unsigned i = 0; i < pulses; i++)
			send_pulse(TIME_W'($urandom), random_width());
		end_phase();
	endtask

	// The receiver holds off for a long stretch while edges keep coming.
	task automatic test_receiver_hold();
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		hold_req     = 1'b1;
		for (int i = 0; i < 20; i++)
			send_pulse(TIME_W'($urandom), random_width());
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		for (int i = 0; i < 10; i++)
			send_pulse(TIME_W'($urandom), random_width());
		end_phase();
	endtask

	// Result side ready: random stalls, and one long hold when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_ch.ready <= 1'b0;
		end else begin
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				range_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				range_ch.ready <= 1'b0;
			end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				range_ch.ready <= 1'b0;
			end else begin
				range_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin : check_ranges
		range_t exp_range;
		if (arst_n && range_ch.valid && range_ch.ready) begin
			if (pending_ranges.size() == 0) begin
				report_error($sformatf("result %0d/%0d with no prediction pending",
					range_ch.pulse_cm, range_ch.average_cm));
			end else begin
				exp_range = pending_ranges.pop_front();
				if (range_ch.pulse_cm !== exp_range.pulse_cm)
					report_error($sformatf("pulse_cm expected %0d, got %0d",
						exp_range.pulse_cm, range_ch.pulse_cm));
				if (range_ch.average_cm !== exp_range.average_cm)
					report_error($sformatf("average_cm expected %0d, got %0d",
						exp_range.average_cm, range_ch.average_cm));
			end
		end
	end

	// Watchdog: too many cycles without any transfer ends the run.
	always @(posedge clk) begin
		if ((echo_ch.valid && echo_ch.ready) || (range_ch.valid && range_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("echo_pulse_ranging_average_top regression: fail");
			$finish;
		end
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		echo_ch.valid      = 1'b0;
		echo_ch.edge_time  = '0;
		range_ch.ready     = 1'b0;
		awaiting_fall      = 1'b0;
		rise_stamp         = '0;
		last_slot          = '0;
		distance_sum       = '0;
		foreach (distance_hist[i])
			distance_hist[i] = '0;
		fail_count   = 0;
		idle_cycles  = 0;
		stall_left   = 0;
		hold_left    = 0;
		hold_req     = 1'b0;
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_widths();
		test_back_to_back(100);
		test_receiver_hold();
		test_random_traffic(420);

		if (fail_count == 0)
			$display("echo_pulse_ranging_average_top regression: pass");
		else
			$display("echo_pulse_ranging_average_top regression: fail");
		$finish;
	end

endmodule
